[rtl/ctlp_pkg.sv]
// Shared types, constants and codes for the caption timecode line parser.
package ctlp_pkg;

    // Default widths of the frame counter and of one parsed field.
    localparam int FRAME_BITS_DEFAULT = 48;
    localparam int FIELD_BITS_DEFAULT = 16;

    // Configuration registers.
    localparam int RATE_BITS      = 16;
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RATE_NUM = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RATE_DEN = 1'b1;
    localparam logic [RATE_BITS-1:0] RATE_NUM_RESET = 16'd30000;
    localparam logic [RATE_BITS-1:0] RATE_DEN_RESET = 16'd1001;

    // Timecode weights.
    localparam int SEC_PER_HOUR = 3600;
    localparam int SEC_PER_MIN  = 60;

    // Character codes.
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_SEMI    = 8'h3B;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F = 8'h66;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Classified byte as it travels through the queue.
    typedef struct packed {
        logic       newline;
        logic       blank;
        logic       colon;
        logic       semi;
        logic       dec;
        logic       hex;
        logic [3:0] value;
    } char_class_t;

    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_HOURS   = 3'd1,
        PH_MINUTES = 3'd2,
        PH_SECONDS = 3'd3,
        PH_FRAMES  = 3'd4,
        PH_AFTER_F = 3'd5,
        PH_WORDS   = 3'd6
    } line_phase_t;

    typedef enum logic {
        BK_RUN  = 1'b0,
        BK_CONV = 1'b1
    } back_state_t;

    typedef enum logic [1:0] {
        CV_IDLE = 2'd0,
        CV_MUL  = 2'd1,
        CV_DIV  = 2'd2,
        CV_ADD  = 2'd3
    } conv_state_t;

endpackage

[rtl/ctlp_front.sv]
// Front end: classifies incoming bytes and holds them in a two-entry queue.
module ctlp_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] char_byte
    output logic                  head_valid,
    output ctlp_pkg::char_class_t head_class,
    input  logic                  pop
);

    function automatic ctlp_pkg::char_class_t classify(input logic [7:0] c);
        ctlp_pkg::char_class_t r;
        r         = '0;
        r.newline = (c == ctlp_pkg::CHAR_NEWLINE);
        r.blank   = (c == ctlp_pkg::CHAR_SPACE) || (c == ctlp_pkg::CHAR_TAB);
        r.colon   = (c == ctlp_pkg::CHAR_COLON);
        r.semi    = (c == ctlp_pkg::CHAR_SEMI);
        if (c >= ctlp_pkg::CHAR_DIGIT_0 && c <= ctlp_pkg::CHAR_DIGIT_9) begin
            r.dec   = 1'b1;
            r.hex   = 1'b1;
            r.value = 4'(c - ctlp_pkg::CHAR_DIGIT_0);
        end else if (c >= ctlp_pkg::CHAR_LOWER_A && c <= ctlp_pkg::CHAR_LOWER_F) begin
            r.hex   = 1'b1;
            r.value = 4'(c - ctlp_pkg::CHAR_LOWER_A + 8'd10);
        end else if (c >= ctlp_pkg::CHAR_UPPER_A && c <= ctlp_pkg::CHAR_UPPER_F) begin
            r.hex   = 1'b1;
            r.value = 4'(c - ctlp_pkg::CHAR_UPPER_A + 8'd10);
        end
        return r;
    endfunction

    ctlp_pkg::char_class_t entry_reg [ctlp_pkg::QUEUE_DEPTH];
    logic [ctlp_pkg::QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ctlp_pkg::QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ctlp_pkg::QCNT_BITS-1:0] count_reg, count_next;
    logic push;

    assign s_tready   = (count_reg != ctlp_pkg::QCNT_BITS'(ctlp_pkg::QUEUE_DEPTH));
    assign push       = s_tvalid && s_tready;
    assign head_valid = (count_reg != '0);
    assign head_class = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= classify(s_tdata);
        end
    end

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("queue popped while empty");

endmodule

[rtl/ctlp_conv.sv]
// Timecode converter: holds the rate registers and turns H:M:S:F into a frame value.
module ctlp_conv #(
    parameter int FRAME_BITS = ctlp_pkg::FRAME_BITS_DEFAULT,
    parameter int FIELD_BITS = ctlp_pkg::FIELD_BITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [ctlp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [ctlp_pkg::RATE_BITS-1:0]      cfg_wr_data,
    input  logic                                start,
    input  logic [FIELD_BITS-1:0]               hours,
    input  logic [FIELD_BITS-1:0]               minutes,
    input  logic [FIELD_BITS-1:0]               seconds,
    input  logic [FIELD_BITS-1:0]               frames,
    output logic                                done,
    output logic [FRAME_BITS-1:0]               value
);

    localparam int RB       = ctlp_pkg::RATE_BITS;
    // H*3600 + M*60 + S stays below 3661 * 2^FIELD_BITS.
    localparam int T_BITS   = FIELD_BITS + 12;
    localparam int P_BITS   = T_BITS + RB;
    localparam int CNT_BITS = $clog2(P_BITS);
    localparam int EXT_BITS = (P_BITS + 1 > FRAME_BITS) ? P_BITS + 1 : FRAME_BITS + 1;

    ctlp_pkg::conv_state_t state_reg, state_next;
    logic [RB-1:0]         rate_num_reg, rate_num_next;
    logic [RB-1:0]         rate_den_reg, rate_den_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [P_BITS-1:0]     mcand_reg, mcand_next;
    logic [RB-1:0]         mplier_reg, mplier_next;
    logic [P_BITS-1:0]     prod_reg, prod_next;
    logic [RB-1:0]         rem_reg, rem_next;
    logic                  done_reg, done_next;
    logic [FRAME_BITS-1:0] value_reg, value_next;

    logic [RB-1:0]       den_eff;
    logic [T_BITS-1:0]   tc_sum;
    logic [RB:0]         trial;
    logic [RB:0]         trial_sub;
    logic                trial_ge;
    logic [EXT_BITS-1:0] sum_ext;

    assign done  = done_reg;
    assign value = value_reg;

    assign den_eff   = (rate_den_reg == '0) ? RB'(1) : rate_den_reg;
    assign tc_sum    = T_BITS'(hours) * T_BITS'(ctlp_pkg::SEC_PER_HOUR)
                     + T_BITS'(minutes) * T_BITS'(ctlp_pkg::SEC_PER_MIN)
                     + T_BITS'(seconds);
    assign trial     = {rem_reg, prod_reg[P_BITS-1]};
    assign trial_ge  = (trial >= {1'b0, den_eff});
    assign trial_sub = trial - {1'b0, den_eff};
    assign sum_ext   = EXT_BITS'(prod_reg) + EXT_BITS'(frames);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ctlp_pkg::CV_IDLE: if (start) state_next = ctlp_pkg::CV_MUL;
            ctlp_pkg::CV_MUL:  if (cnt_reg == '0) state_next = ctlp_pkg::CV_DIV;
            ctlp_pkg::CV_DIV:  if (cnt_reg == '0) state_next = ctlp_pkg::CV_ADD;
            ctlp_pkg::CV_ADD:  state_next = ctlp_pkg::CV_IDLE;
            default:           state_next = ctlp_pkg::CV_IDLE;
        endcase
    end

    always_comb begin
        rate_num_next = rate_num_reg;
        rate_den_next = rate_den_reg;
        cnt_next      = cnt_reg;
        mcand_next    = mcand_reg;
        mplier_next   = mplier_reg;
        prod_next     = prod_reg;
        rem_next      = rem_reg;
        done_next     = 1'b0;
        value_next    = value_reg;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                ctlp_pkg::REG_RATE_NUM: rate_num_next = cfg_wr_data;
                ctlp_pkg::REG_RATE_DEN: rate_den_next = cfg_wr_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ctlp_pkg::CV_IDLE: begin
                if (start) begin
                    mcand_next  = P_BITS'(tc_sum);
                    mplier_next = rate_num_reg;
                    prod_next   = '0;
                    rem_next    = '0;
                    cnt_next    = CNT_BITS'(RB - 1);
                end
            end
            ctlp_pkg::CV_MUL: begin
                // Shift-and-add, one bit of the numerator a cycle.
                if (mplier_reg[0]) begin
                    prod_next = prod_reg + mcand_reg;
                end
                mcand_next  = {mcand_reg[P_BITS-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[RB-1:1]};
                cnt_next    = (cnt_reg == '0) ? CNT_BITS'(P_BITS - 1) : cnt_reg - 1'b1;
            end
            ctlp_pkg::CV_DIV: begin
                // Restoring division; the quotient shifts into the product register.
                rem_next  = trial_ge ? trial_sub[RB-1:0] : trial[RB-1:0];
                prod_next = {prod_reg[P_BITS-2:0], trial_ge};
                cnt_next  = cnt_reg - 1'b1;
            end
            ctlp_pkg::CV_ADD: begin
                if (sum_ext > EXT_BITS'({FRAME_BITS{1'b1}})) begin
                    value_next = '1;
                end else begin
                    value_next = sum_ext[FRAME_BITS-1:0];
                end
                done_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ctlp_pkg::CV_IDLE;
            rate_num_reg <= ctlp_pkg::RATE_NUM_RESET;
            rate_den_reg <= ctlp_pkg::RATE_DEN_RESET;
            cnt_reg      <= '0;
            done_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rate_num_reg <= rate_num_next;
            rate_den_reg <= rate_den_next;
            cnt_reg      <= cnt_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        prod_reg   <= prod_next;
        rem_reg    <= rem_next;
        value_reg  <= value_next;
    end

    a_start_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> state_reg == ctlp_pkg::CV_IDLE)
        else $error("conversion started while busy");

    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg && state_reg == ctlp_pkg::CV_IDLE)
        else $error("done held for more than one cycle");

endmodule

[rtl/ctlp_back.sv]
// Back end: line parser state machine, frame counter and output register.
module ctlp_back #(
    parameter int FRAME_BITS = ctlp_pkg::FRAME_BITS_DEFAULT,
    parameter int FIELD_BITS = ctlp_pkg::FIELD_BITS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  head_valid,
    input  ctlp_pkg::char_class_t head_class,
    output logic                  pop,
    output logic                  conv_start,
    output logic [FIELD_BITS-1:0] conv_hours,
    output logic [FIELD_BITS-1:0] conv_minutes,
    output logic [FIELD_BITS-1:0] conv_seconds,
    output logic [FIELD_BITS-1:0] conv_frames,
    input  logic                  conv_done,
    input  logic [FRAME_BITS-1:0] conv_value,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [FIELD_BITS-1:0] m_word,
    output logic [FRAME_BITS-1:0] m_frame
);

    localparam int ACC_W = FIELD_BITS + 5;

    ctlp_pkg::back_state_t state_reg, state_next;
    ctlp_pkg::line_phase_t phase_reg, phase_next;
    logic                  skip_reg, skip_next;
    logic [FIELD_BITS-1:0] hours_reg, hours_next;
    logic [FIELD_BITS-1:0] minutes_reg, minutes_next;
    logic [FIELD_BITS-1:0] seconds_reg, seconds_next;
    logic [FIELD_BITS-1:0] frames_reg, frames_next;
    logic [FIELD_BITS-1:0] word_reg, word_next;
    logic                  word_active_reg, word_active_next;
    logic [FRAME_BITS-1:0] frame_cnt_reg, frame_cnt_next;
    logic                  m_valid_reg, m_valid_next;
    logic [FIELD_BITS-1:0] m_word_reg, m_word_next;
    logic [FRAME_BITS-1:0] m_frame_reg, m_frame_next;

    ctlp_pkg::char_class_t c;
    logic                  need_conv;
    logic                  emit;
    logic                  do_newline;
    logic                  do_between;
    logic                  out_free;
    logic [FIELD_BITS-1:0] acc_in;
    logic [ACC_W-1:0]      acc_wide;
    logic [FIELD_BITS-1:0] acc_sat;
    logic [FRAME_BITS-1:0] frame_inc;

    assign c            = head_class;
    assign conv_start   = need_conv;
    assign conv_hours   = hours_reg;
    assign conv_minutes = minutes_reg;
    assign conv_seconds = seconds_reg;
    assign conv_frames  = frames_reg;
    assign m_tvalid     = m_valid_reg;
    assign m_word       = m_word_reg;
    assign m_frame      = m_frame_reg;
    assign out_free     = !m_valid_reg || m_tready;
    assign frame_inc    = frame_cnt_reg + 1'b1;

    // One shared saturating digit accumulator; the phase picks the field.
    always_comb begin
        case (phase_reg)
            ctlp_pkg::PH_HOURS:   acc_in = hours_reg;
            ctlp_pkg::PH_MINUTES: acc_in = minutes_reg;
            ctlp_pkg::PH_SECONDS: acc_in = seconds_reg;
            ctlp_pkg::PH_FRAMES:  acc_in = frames_reg;
            default:              acc_in = word_reg;
        endcase
        if (phase_reg == ctlp_pkg::PH_WORDS) begin
            acc_wide = ACC_W'({acc_in, 4'b0000}) + ACC_W'(c.value);
        end else begin
            acc_wide = ACC_W'({acc_in, 3'b000}) + ACC_W'({acc_in, 1'b0}) + ACC_W'(c.value);
        end
        acc_sat = (acc_wide[ACC_W-1:FIELD_BITS] != '0) ? '1 : acc_wide[FIELD_BITS-1:0];
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ctlp_pkg::BK_RUN:  if (need_conv) state_next = ctlp_pkg::BK_CONV;
            ctlp_pkg::BK_CONV: if (conv_done) state_next = ctlp_pkg::BK_RUN;
            default:           state_next = ctlp_pkg::BK_RUN;
        endcase
    end

    always_comb begin
        phase_next       = phase_reg;
        skip_next        = skip_reg;
        hours_next       = hours_reg;
        minutes_next     = minutes_reg;
        seconds_next     = seconds_reg;
        frames_next      = frames_reg;
        word_next        = word_reg;
        word_active_next = word_active_reg;
        frame_cnt_next   = frame_cnt_reg;
        pop              = 1'b0;
        need_conv        = 1'b0;
        emit             = 1'b0;
        do_newline       = 1'b0;
        do_between       = 1'b0;

        if (state_reg == ctlp_pkg::BK_RUN && head_valid) begin
            if (skip_reg) begin
                pop        = 1'b1;
                do_newline = c.newline;
            end else begin
                unique case (phase_reg)
                    ctlp_pkg::PH_START: begin
                        pop = 1'b1;
                        if (c.newline) begin
                            do_newline = 1'b1;
                        end else if (c.blank) begin
                        end else if (c.dec) begin
                            hours_next = FIELD_BITS'(c.value);
                            phase_next = ctlp_pkg::PH_HOURS;
                        end else begin
                            skip_next = 1'b1;
                        end
                    end
                    ctlp_pkg::PH_HOURS: begin
                        pop = 1'b1;
                        if (c.newline) begin
                            do_newline = 1'b1;
                        end else if (c.dec) begin
                            hours_next = acc_sat;
                        end else if (c.colon) begin
                            phase_next = ctlp_pkg::PH_MINUTES;
                        end else begin
                            skip_next = 1'b1;
                        end
                    end
                    ctlp_pkg::PH_MINUTES: begin
                        pop = 1'b1;
                        if (c.newline) begin
                            do_newline = 1'b1;
                        end else if (c.dec) begin
                            minutes_next = acc_sat;
                        end else if (c.colon) begin
                            phase_next = ctlp_pkg::PH_SECONDS;
                        end else begin
                            skip_next = 1'b1;
                        end
                    end
                    ctlp_pkg::PH_SECONDS: begin
                        pop = 1'b1;
                        if (c.newline) begin
                            do_newline = 1'b1;
                        end else if (c.dec) begin
                            seconds_next = acc_sat;
                        end else if (c.colon || c.semi) begin
                            phase_next = ctlp_pkg::PH_FRAMES;
                        end else begin
                            skip_next = 1'b1;
                        end
                    end
                    ctlp_pkg::PH_FRAMES: begin
                        // Any other byte, newline included, triggers the conversion
                        // and is handled again once the frame counter is updated.
                        if (c.dec) begin
                            pop         = 1'b1;
                            frames_next = acc_sat;
                        end else if (c.blank) begin
                            pop        = 1'b1;
                            phase_next = ctlp_pkg::PH_AFTER_F;
                        end else begin
                            need_conv = 1'b1;
                        end
                    end
                    ctlp_pkg::PH_AFTER_F: begin
                        if (c.blank) begin
                            pop = 1'b1;
                        end else begin
                            need_conv = 1'b1;
                        end
                    end
                    ctlp_pkg::PH_WORDS: begin
                        if (word_active_reg && c.hex) begin
                            pop       = 1'b1;
                            word_next = acc_sat;
                        end else if (word_active_reg) begin
                            // The word ends here; wait for room in the output register.
                            if (out_free) begin
                                pop              = 1'b1;
                                emit             = 1'b1;
                                frame_cnt_next   = frame_inc;
                                word_next        = '0;
                                word_active_next = 1'b0;
                                do_between       = 1'b1;
                            end
                        end else begin
                            pop        = 1'b1;
                            do_between = 1'b1;
                        end
                    end
                    default: begin
                        pop        = 1'b1;
                        do_newline = 1'b1;
                    end
                endcase
            end
        end

        if (state_reg == ctlp_pkg::BK_CONV && conv_done) begin
            if (frame_cnt_reg < conv_value) begin
                frame_cnt_next = conv_value;
            end
            phase_next = ctlp_pkg::PH_WORDS;
        end

        // Byte between words.
        if (do_between) begin
            if (c.newline) begin
                do_newline = 1'b1;
            end else if (c.blank) begin
            end else if (c.hex) begin
                word_next        = FIELD_BITS'(c.value);
                word_active_next = 1'b1;
            end else begin
                skip_next = 1'b1;
            end
        end

        if (do_newline) begin
            phase_next       = ctlp_pkg::PH_START;
            skip_next        = 1'b0;
            hours_next       = '0;
            minutes_next     = '0;
            seconds_next     = '0;
            frames_next      = '0;
            word_next        = '0;
            word_active_next = 1'b0;
        end
    end

    always_comb begin
        m_word_next  = m_word_reg;
        m_frame_next = m_frame_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_word_next  = word_reg;
            m_frame_next = frame_inc;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ctlp_pkg::BK_RUN;
            phase_reg       <= ctlp_pkg::PH_START;
            skip_reg        <= 1'b0;
            hours_reg       <= '0;
            minutes_reg     <= '0;
            seconds_reg     <= '0;
            frames_reg      <= '0;
            word_reg        <= '0;
            word_active_reg <= 1'b0;
            frame_cnt_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            skip_reg        <= skip_next;
            hours_reg       <= hours_next;
            minutes_reg     <= minutes_next;
            seconds_reg     <= seconds_next;
            frames_reg      <= frames_next;
            word_reg        <= word_next;
            word_active_reg <= word_active_next;
            frame_cnt_reg   <= frame_cnt_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_word_reg  <= m_word_next;
        m_frame_reg <= m_frame_next;
    end

    a_word_in_words: assert property (@(posedge aclk) disable iff (!aresetn)
        word_active_reg |-> phase_reg == ctlp_pkg::PH_WORDS)
        else $error("word active outside the word phase");

    a_conv_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ctlp_pkg::BK_CONV |->
            phase_reg == ctlp_pkg::PH_FRAMES || phase_reg == ctlp_pkg::PH_AFTER_F)
        else $error("conversion pending outside the frames field");

endmodule

[rtl/caption_timecode_line_parser.sv]
// Top level of the caption timecode line parser: front queue, parser and converter.
// The parser takes one byte per cycle while no conversion runs and the output register
// has room; the first non-blank byte after the F field of a line stalls the parser while
// the timecode is scaled by a 16-step shift-add multiplier and a bit-serial divider.
// A caption word is presented on m_tvalid from the output register, loaded when the byte
// that ends it leaves the queue. Reset (aresetn low at a clock edge) empties the queue,
// restarts the line, clears the frame counter, sets the rate registers to 30000 / 1001.
module caption_timecode_line_parser #(
    parameter int FRAME_BITS = ctlp_pkg::FRAME_BITS_DEFAULT,
    parameter int FIELD_BITS = ctlp_pkg::FIELD_BITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration writes: index 0 is rate_numerator, index 1 is rate_denominator.
    input  logic                                cfg_wr_en,
    input  logic [ctlp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [ctlp_pkg::RATE_BITS-1:0]      cfg_wr_data,
    // Byte stream of the caption file.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,  // [7:0] char_byte
    // Caption words with their frame numbers.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // From bit 0 up: caption_word (FIELD_BITS), frame_number (FRAME_BITS), zero padding.
    output logic [((FIELD_BITS + FRAME_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int M_DATA_BITS = ((FIELD_BITS + FRAME_BITS + 7) / 8) * 8;

    // The front classifies each byte as it arrives and parks it in a short queue, so that
    // the input keeps taking bytes while the parser waits on a full output register.
    logic                  head_valid;
    ctlp_pkg::char_class_t head_class;
    logic                  pop;

    // Request and answer of the timecode conversion.
    logic                  conv_start;
    logic [FIELD_BITS-1:0] conv_hours;
    logic [FIELD_BITS-1:0] conv_minutes;
    logic [FIELD_BITS-1:0] conv_seconds;
    logic [FIELD_BITS-1:0] conv_frames;
    logic                  conv_done;
    logic [FRAME_BITS-1:0] conv_value;

    // Registered result from the parser.
    logic [FIELD_BITS-1:0] m_word;
    logic [FRAME_BITS-1:0] m_frame;

    ctlp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .head_valid (head_valid),
        .head_class (head_class),
        .pop        (pop)
    );

    // The parser walks the line phases. When the timecode is complete it hands the four
    // fields to the converter, holds the current byte, and resumes once the frame counter
    // has been raised to the converted value where it was lower.
    ctlp_back #(
        .FRAME_BITS (FRAME_BITS),
        .FIELD_BITS (FIELD_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_valid   (head_valid),
        .head_class   (head_class),
        .pop          (pop),
        .conv_start   (conv_start),
        .conv_hours   (conv_hours),
        .conv_minutes (conv_minutes),
        .conv_seconds (conv_seconds),
        .conv_frames  (conv_frames),
        .conv_done    (conv_done),
        .conv_value   (conv_value),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_word       (m_word),
        .m_frame      (m_frame)
    );

    // The converter owns the rate registers; a zero denominator is taken as one.
    ctlp_conv #(
        .FRAME_BITS (FRAME_BITS),
        .FIELD_BITS (FIELD_BITS)
    ) u_conv (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .start       (conv_start),
        .hours       (conv_hours),
        .minutes     (conv_minutes),
        .seconds     (conv_seconds),
        .frames      (conv_frames),
        .done        (conv_done),
        .value       (conv_value)
    );

    assign m_tdata = M_DATA_BITS'({m_frame, m_word});

endmodule
